@@ design/u8cpd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and decode helpers for the UTF-8 to code point decoder.
// No dependencies; imported by every module of the decoder.
package u8cpd_pkg;

	localparam int ByteW     = 8;
	localparam int CpW       = 21;
	localparam int InTdataW  = 8;
	localparam int OutTdataW = 24;

	typedef logic [ByteW-1:0] byte_t;
	typedef logic [CpW-1:0]   cp_t;

	localparam cp_t CpQmark = cp_t'(63);

	// Lead byte prefixes
	localparam logic [2:0] LeadPfx2 = 3'h6;
	localparam logic [3:0] LeadPfx3 = 4'hE;
	localparam logic [4:0] LeadPfx4 = 5'h1E;

	// Sequence length codes returned by lead_len
	localparam logic [2:0] LenBad   = 3'd0;
	localparam logic [2:0] LenAscii = 3'd1;
	localparam logic [2:0] LenTwo   = 3'd2;
	localparam logic [2:0] LenThree = 3'd3;
	localparam logic [2:0] LenFour  = 3'd4;

	// Control state of the open sequence
	typedef struct packed {
		byte_t      lead;
		logic [1:0] needed;
		logic [1:0] held;
	} dec_ctl_t;

	// Next state plus tail buffer write
	typedef struct packed {
		dec_ctl_t nxt;
		logic     tail_we;
		logic     tail_idx;
	} dec_upd_t;

	// Results of one byte, cp0 delivered first
	typedef struct packed {
		logic [1:0] cnt;
		cp_t        cp2;
		cp_t        cp1;
		cp_t        cp0;
	} dec_res_t;

	function automatic logic [2:0] lead_len(input byte_t b);
		logic [2:0] n;
		if (!b[7]) begin
			n = LenAscii;
		end else if (b[7:5] == LeadPfx2) begin
			n = LenTwo;
		end else if (b[7:4] == LeadPfx3) begin
			n = LenThree;
		end else if (b[7:3] == LeadPfx4) begin
			n = LenFour;
		end else begin
			n = LenBad;
		end
		return n;
	endfunction

	// A byte taken on its own: ASCII passes, anything else is '?'
	function automatic cp_t single_cp(input byte_t b);
		return b[7] ? CpQmark : cp_t'(b);
	endfunction

	function automatic cp_t merge2(input byte_t l, input byte_t c);
		return cp_t'({l[4:0], c[5:0]});
	endfunction

	function automatic cp_t merge3(input byte_t l, input byte_t c1, input byte_t c2);
		return cp_t'({l[3:0], c1[5:0], c2[5:0]});
	endfunction

	function automatic cp_t merge4(input byte_t l, input byte_t c1, input byte_t c2,
		input byte_t c3);
		return cp_t'({l[2:0], c1[5:0], c2[5:0], c3[5:0]});
	endfunction

endpackage

@@ design/u8cpd_decode.sv @@
`timescale 1ns / 1ps
// Single-pass decode of one byte against the open-sequence state: next state,
// tail buffer write and up to three code points. Depends on u8cpd_pkg.
module u8cpd_decode (
	input  u8cpd_pkg::dec_ctl_t ctl,
	input  u8cpd_pkg::byte_t    tail0,
	input  u8cpd_pkg::byte_t    tail1,
	input  u8cpd_pkg::byte_t    byte_in,
	input  logic                eos,
	output u8cpd_pkg::dec_upd_t upd,
	output u8cpd_pkg::dec_res_t res
);
	import u8cpd_pkg::*;

	logic [2:0] len_b;
	logic [2:0] len_t0;
	logic [2:0] held_inc;
	logic [2:0] needed_w;

	always_comb begin
		len_b    = lead_len(byte_in);
		len_t0   = lead_len(tail0);
		held_inc = {1'b0, ctl.held} + 3'd1;
		needed_w = {1'b0, ctl.needed};

		upd.nxt      = ctl;
		upd.tail_we  = 1'b0;
		upd.tail_idx = ctl.held[0];
		res          = '0;

		if (ctl.needed == 2'd0) begin
			if ((len_b >= LenTwo) && !eos) begin
				// open a sequence
				upd.nxt.lead   = byte_in;
				upd.nxt.needed = 2'(len_b - 3'd1);
				upd.nxt.held   = 2'd0;
			end else begin
				res.cnt = 2'd1;
				res.cp0 = single_cp(byte_in);
			end
		end else if ((held_inc < needed_w) && !eos) begin
			// buffer a following byte
			upd.tail_we  = 1'b1;
			upd.nxt.held = 2'(held_inc);
		end else begin
			upd.nxt = '0;
			if (held_inc >= needed_w) begin
				res.cnt = 2'd1;
				case (ctl.needed)
					2'd1:    res.cp0 = merge2(ctl.lead, byte_in);
					2'd2:    res.cp0 = merge3(ctl.lead, tail0, byte_in);
					default: res.cp0 = merge4(ctl.lead, tail0, tail1, byte_in);
				endcase
			end else begin
				// truncated: lead gives '?', then redecode the buffered tail
				res.cp0 = CpQmark;
				if (ctl.held == 2'd0) begin
					res.cnt = 2'd2;
					res.cp1 = single_cp(byte_in);
				end else if (len_t0 == LenTwo) begin
					res.cnt = 2'd2;
					res.cp1 = merge2(tail0, byte_in);
				end else begin
					res.cnt = 2'd3;
					res.cp1 = single_cp(tail0);
					res.cp2 = single_cp(byte_in);
				end
			end
		end
	end

endmodule

@@ design/utf8_to_codepoint_decoder_unit.sv @@
`timescale 1ns / 1ps
// Bytes pass the input register, code points the three-entry result register.
// Throughput: one byte per cycle while the result register is free; a string
// that ends inside a sequence gives up to three code points, one per cycle as
// m_tready allows. Reset (arst_n low, asynchronous): input and result registers
// empty, no sequence open. Depends on u8cpd_pkg and u8cpd_decode.
module utf8_to_codepoint_decoder_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [u8cpd_pkg::InTdataW-1:0]     s_tdata,  // [7:0] byte_value
	input  logic                               s_tlast,  // end_of_string
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [u8cpd_pkg::OutTdataW-1:0]    m_tdata,  // [20:0] code_point, rest zero
	output logic                               m_tlast   // run_last
);
	import u8cpd_pkg::*;

	logic     valid_s1;
	byte_t    byte_s1;
	logic     eos_s1;

	dec_ctl_t ctl_q;
	byte_t    tail_q [2];

	logic [1:0] ob_cnt_q;
	cp_t        ob_cp_q [3];

	dec_upd_t upd;
	dec_res_t res;
	logic     out_xfer;
	logic     out_free;
	logic     advance;

	u8cpd_decode u_decode (
		.ctl     (ctl_q),
		.tail0   (tail_q[0]),
		.tail1   (tail_q[1]),
		.byte_in (byte_s1),
		.eos     (eos_s1),
		.upd     (upd),
		.res     (res)
	);

	assign out_xfer = m_tvalid && m_tready;
	assign out_free = (ob_cnt_q == 2'd0) || ((ob_cnt_q == 2'd1) && out_xfer);
	assign advance  = valid_s1 && ((res.cnt == 2'd0) || out_free);
	assign s_tready = !valid_s1 || advance;

	assign m_tvalid = (ob_cnt_q != 2'd0);
	assign m_tlast  = (ob_cnt_q == 2'd1);
	assign m_tdata  = OutTdataW'(ob_cp_q[0]);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[ByteW-1:0];
			eos_s1  <= s_tlast;
		end
	end

	// sequence state, updated as each byte leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (advance) begin
			ctl_q <= upd.nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && upd.tail_we) begin
			tail_q[upd.tail_idx] <= byte_s1;
		end
	end

	// result register: load a new run or shift out one transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_cnt_q <= 2'd0;
		end else if (advance && (res.cnt != 2'd0)) begin
			ob_cnt_q <= res.cnt;
		end else if (out_xfer) begin
			ob_cnt_q <= ob_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (res.cnt != 2'd0)) begin
			ob_cp_q[0] <= res.cp0;
			ob_cp_q[1] <= res.cp1;
			ob_cp_q[2] <= res.cp2;
		end else if (out_xfer) begin
			ob_cp_q[0] <= ob_cp_q[1];
			ob_cp_q[1] <= ob_cp_q[2];
		end
	end

endmodule

@@ design/u8cpd_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the UTF-8 decoder, bound to the top level.
// Depends on u8cpd_pkg and utf8_to_codepoint_decoder_unit.
module u8cpd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [u8cpd_pkg::InTdataW-1:0]  s_tdata,   // [7:0] byte_value
	input logic                            s_tlast,   // end_of_string
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [u8cpd_pkg::OutTdataW-1:0] m_tdata,   // [20:0] code_point
	input logic                            m_tlast    // run_last
);
	import u8cpd_pkg::*;

	logic out_xfer;
	assign out_xfer = m_tvalid && m_tready;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// rest of a run follows in the next cycle
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && !m_tlast |=> m_tvalid)
		else $error("run broken after a non-last transfer");

	// a run holds at most three results
	a_run_max: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && !m_tlast) ##1 (out_xfer && !m_tlast) |=> m_tvalid && m_tlast)
		else $error("run longer than three results");

	// input backpressure only comes from a waiting result
	a_bp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

endmodule

bind utf8_to_codepoint_decoder_unit u8cpd_checker u_checker (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Testbench for utf8_to_codepoint_decoder_unit: streams bytes of UTF-8 strings in
// and checks every code point out.
// Holds its own decoder state to predict results; depends on u8cpd_pkg and the decoder RTL.
module tb;
	import u8cpd_pkg::*;

	localparam int IdleLimit = 1000;
	localparam int RandomBytes = 77;

	typedef struct packed {
		byte_t value;
		logic  eos;
	} str_byte_t;

	typedef struct packed {
		cp_t  cp;
		logic last;
	} cp_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [InTdataW-1:0]  s_tdata = '0;  // [7:0] byte_value
	logic                 s_tlast = 1'b0;  // end_of_string
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OutTdataW-1:0] m_tdata;  // [20:0] code_point, rest zero
	logic                 m_tlast;  // run_last

	utf8_to_codepoint_decoder_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	str_byte_t  byte_queue[$];
	cp_result_t cp_expected[$];

	// Decoder state as the predictor sees it
	byte_t      seq_lead;
	byte_t      seq_tail[2];
	logic [1:0] seq_need;
	logic [1:0] seq_held;

	int mismatches = 0;
	int bytes_sent = 0;
	int strings_sent = 0;
	int cps_checked = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int seq_len(byte_t b);
		if (!b[7]) return 1;
		if (b[7:5] == LeadPfx2) return 2;
		if (b[7:4] == LeadPfx3) return 3;
		if (b[7:3] == LeadPfx4) return 4;
		return 0;
	endfunction

	// Decode a closed run of bytes; a non-lead byte or an uncompleted lead gives '?'
	task automatic expect_run(input byte_t run[4], input int len);
		cp_t        cps[3];
		int         n_out;
		int         i;
		int         n;
		cp_result_t res_item;
		n_out = 0;
		i = 0;
		while (i < len && n_out < 3) begin
			n = seq_len(run[i]);
			if (n == 1) begin
				cps[n_out] = cp_t'(run[i]);
				i++;
			end else if (n >= 2 && i + n - 1 < len) begin
				case (n)
					2: cps[n_out] = cp_t'({run[i][4:0], run[i+1][5:0]});
					3: cps[n_out] = cp_t'({run[i][3:0], run[i+1][5:0], run[i+2][5:0]});
					default: cps[n_out] = cp_t'({run[i][2:0], run[i+1][5:0],
						run[i+2][5:0], run[i+3][5:0]});
				endcase
				i += n;
			end else begin
				cps[n_out] = CpQmark;
				i++;
			end
			n_out++;
		end
		for (int k = 0; k < n_out; k++) begin
			res_item.cp = cps[k];
			res_item.last = (k == n_out - 1);
			cp_expected = {cp_expected, res_item};
		end
	endtask

	task automatic track_byte(input byte_t b, input logic eos);
		byte_t run[4];
		int    len;
		int    n;
		int    held;
		run = '{default: '0};
		if (seq_need == 2'd0) begin
			n = seq_len(b);
			if (n >= 2 && !eos) begin
				seq_lead = b;
				seq_need = 2'(n - 1);
				seq_held = 2'd0;
				return;
			end
			run[0] = b;
			len = 1;
		end else begin
			held = seq_held;
			if (held + 1 < seq_need && !eos) begin
				seq_tail[held] = b;
				seq_held = 2'(held + 1);
				return;
			end
			run[0] = seq_lead;
			if (held > 0) run[1] = seq_tail[0];
			if (held > 1) run[2] = seq_tail[1];
			run[held + 1] = b;
			len = held + 2;
			seq_lead = '0;
			seq_need = 2'd0;
			seq_held = 2'd0;
		end
		expect_run(run, len);
	endtask

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	task automatic queue_byte(input byte_t b, input logic eos);
		str_byte_t item;
		item.value = b;
		item.eos = eos;
		byte_queue = {byte_queue, item};
	endtask

	function automatic byte_t lead_of(int n);
		case (n)
			1: return byte_t'($urandom_range(0, 127));
			2: return {LeadPfx2, 5'($urandom)};
			3: return {LeadPfx3, 4'($urandom)};
			default: return {LeadPfx4, 3'($urandom)};
		endcase
	endfunction

	function automatic byte_t tail_byte();
		return {2'b10, 6'($urandom)};
	endfunction

	// Sender: bursts of random length, random gaps between them
	str_byte_t tx_item;
	int        burst_left;
	int        gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
			burst_left = 8;
			gap_left = 0;
			seq_lead = '0;
			seq_need = 2'd0;
			seq_held = 2'd0;
		end else begin
			if (s_tvalid && s_tready) begin
				track_byte(s_tdata, s_tlast);
				bytes_sent++;
				if (s_tlast) strings_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (byte_queue.size() > 0) begin
					tx_item = byte_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= tx_item.value;
					s_tlast <= tx_item.eos;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 20);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall pattern picked by rx_cycle[7:6], plus one long hold-off
	logic [15:0] rx_cycle;
	int          rx_count;
	int          hold_left;
	bit          hold_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_cycle = '0;
			rx_count = 0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			rx_cycle++;
			if (m_tvalid && m_tready) rx_count++;
			if (!hold_done && rx_count >= 20) begin
				hold_done = 1'b1;
				hold_left = 150;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (rx_cycle[7:6])
					2'd0: m_tready <= 1'b1;
					2'd1: m_tready <= 1'($urandom_range(0, 1));
					2'd2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= rx_cycle[1];
				endcase
			end
		end
	end

	// Check each transfer out against the oldest expected code point
	cp_result_t rx_want;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (cp_expected.size() == 0) begin
				note_mismatch($sformatf("code point 0x%0h (last %0b) with nothing expected",
					m_tdata, m_tlast));
			end else begin
				rx_want = cp_expected.pop_front();
				cps_checked++;
				if (m_tdata[CpW-1:0] !== rx_want.cp)
					note_mismatch($sformatf("code_point: expected 0x%0h, got 0x%0h",
						rx_want.cp, m_tdata[CpW-1:0]));
				if (m_tdata[OutTdataW-1:CpW] !== '0)
					note_mismatch($sformatf("tdata padding: expected 0, got 0x%0h",
						m_tdata[OutTdataW-1:CpW]));
				if (m_tlast !== rx_want.last)
					note_mismatch($sformatf("run_last: expected %0b, got %0b",
						rx_want.last, m_tlast));
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("Timeout after %0d cycles without a transfer", IdleLimit);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	int kind;
	int n;
	int m;
	bit eos_tail;
	int directed_count;

	initial begin
		// Plain bytes and invalid leads
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h7F, 1'b1);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hF8, 1'b0);
		// Complete two-, three- and four-byte sequences
		queue_byte(8'hC3, 1'b0);
		queue_byte(8'hA9, 1'b0);
		queue_byte(8'hE2, 1'b0);
		queue_byte(8'h82, 1'b0);
		queue_byte(8'hAC, 1'b0);
		queue_byte(8'hF0, 1'b0);
		queue_byte(8'h9F, 1'b0);
		queue_byte(8'h98, 1'b0);
		queue_byte(8'h80, 1'b0);
		// Overlong lead followed by a byte that is no continuation byte
		queue_byte(8'hC0, 1'b0);
		queue_byte(8'h41, 1'b0);
		// Lead that is the last byte of its string
		queue_byte(8'hE2, 1'b1);
		// String ends inside a four-byte sequence: three results
		queue_byte(8'hF4, 1'b0);
		queue_byte(8'h41, 1'b0);
		queue_byte(8'hE2, 1'b1);
		// String ends inside a four-byte sequence whose tail re-decodes whole
		queue_byte(8'hF0, 1'b0);
		queue_byte(8'hC3, 1'b0);
		queue_byte(8'hA9, 1'b1);
		directed_count = byte_queue.size();

		while (byte_queue.size() < directed_count + RandomBytes) begin
			kind = $urandom_range(0, 9);
			if (kind <= 6) begin
				n = $urandom_range(1, 4);
				eos_tail = ($urandom_range(0, 4) == 0);
				queue_byte(lead_of(n), eos_tail && n == 1);
				for (int k = 1; k < n; k++)
					queue_byte(tail_byte(), eos_tail && k == n - 1);
			end else if (kind == 7) begin
				// truncated sequence, final byte anything
				n = $urandom_range(2, 4);
				m = $urandom_range(0, n - 2);
				queue_byte(lead_of(n), m == 0);
				for (int k = 1; k < m; k++)
					queue_byte(tail_byte(), 1'b0);
				if (m > 0)
					queue_byte(byte_t'($urandom_range(0, 255)), 1'b1);
			end else if (kind == 8) begin
				queue_byte(byte_t'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			end else begin
				// lead with arbitrary followers
				n = $urandom_range(2, 4);
				queue_byte(lead_of(n), 1'b0);
				for (int k = 1; k < n; k++)
					queue_byte(byte_t'($urandom_range(0, 255)), 1'b0);
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_queue.size() != 0 || s_tvalid) @(negedge clk);
		while (cp_expected.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);

		$display("Sent %0d bytes in %0d strings, checked %0d code points",
			bytes_sent, strings_sent, cps_checked);
		$display("Covered all sequence lengths, invalid and truncated leads, and a long output stall");
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d mismatches in total", mismatches);
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
